// ===== hdl/hjd_pkg.sv =====
package hjd_pkg;

   localparam int CFG_WIDTH = 16;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic [1:0] {
      CSR_DETECT_DEBOUNCE = 2'd0,
      CSR_POLE_SETTLE     = 2'd1,
      CSR_BUTTON_DEBOUNCE = 2'd2
   } csr_index_type;

   localparam logic [CFG_WIDTH-1:0] DETECT_DEBOUNCE_RESET = 16'd500;
   localparam logic [CFG_WIDTH-1:0] POLE_SETTLE_RESET     = 16'd50;
   localparam logic [CFG_WIDTH-1:0] BUTTON_DEBOUNCE_RESET = 16'd200;

   typedef enum logic [1:0] {
      JACK_NONE  = 2'd0,
      JACK_FOUR  = 2'd1,
      JACK_THREE = 2'd2
   } jack_kind_type;

   typedef struct packed {
      logic          last_detect;
      logic          last_button;
      jack_kind_type present_kind;
      logic          settling;
      logic          pend_detect;
      logic          pend_press;
      logic          pend_release;
      logic          button_armed;
      logic          held;
      logic          mic_drive;
   } hjd_state_type;

   localparam hjd_state_type STATE_RESET = '{
      last_detect:  1'b1,
      last_button:  1'b0,
      present_kind: JACK_NONE,
      settling:     1'b0,
      pend_detect:  1'b0,
      pend_press:   1'b0,
      pend_release: 1'b0,
      button_armed: 1'b0,
      held:         1'b0,
      mic_drive:    1'b0
   };

   typedef struct packed {
      logic [CFG_WIDTH-1:0] detect_debounce_ticks;
      logic [CFG_WIDTH-1:0] pole_settle_ticks;
      logic [CFG_WIDTH-1:0] button_debounce_ticks;
   } hjd_cfg_type;

   // Field order matches the result tdata layout from bit 7 down.
   typedef struct packed {
      logic          button_event;
      logic          jack_event;
      logic          button_down;
      logic          microphone_present;
      logic          headphone_present;
      logic          mic_enable;
      jack_kind_type jack_state;
   } hjd_result_type;

endpackage

// ===== hdl/hjd_core.sv =====
module hjd_core #(
   parameter int TIMER_WIDTH = 16
) (
   input  hjd_pkg::hjd_cfg_type    cfg,
   input  logic                    detect_level,
   input  logic                    pole_level,
   input  logic                    button_level,
   input  hjd_pkg::hjd_state_type  state_cur,
   input  logic [TIMER_WIDTH-1:0]  detect_timer_cur,
   input  logic [TIMER_WIDTH-1:0]  settle_timer_cur,
   input  logic [TIMER_WIDTH-1:0]  press_timer_cur,
   input  logic [TIMER_WIDTH-1:0]  release_timer_cur,
   output hjd_pkg::hjd_state_type  state_nxt,
   output logic [TIMER_WIDTH-1:0]  detect_timer_nxt,
   output logic [TIMER_WIDTH-1:0]  settle_timer_nxt,
   output logic [TIMER_WIDTH-1:0]  press_timer_nxt,
   output logic [TIMER_WIDTH-1:0]  release_timer_nxt,
   output hjd_pkg::hjd_result_type result
);

   localparam logic [63:0] TIMER_MAX64 = (64'd1 << TIMER_WIDTH) - 64'd1;
   localparam logic [31:0] TIMER_MAX = TIMER_MAX64[31:0];

   // A delay beyond the timer range saturates.
   function automatic logic [TIMER_WIDTH-1:0] clamp_delay(input logic [hjd_pkg::CFG_WIDTH-1:0] d);
      logic [31:0] d32;
      d32 = 32'(d);
      if (d32 > TIMER_MAX) begin
         return TIMER_WIDTH'(TIMER_MAX);
      end
      return TIMER_WIDTH'(d32);
   endfunction

   // Advances a pending timer; fire is set when it expires this tick.
   function automatic void tick_timer(inout logic pend, inout logic [TIMER_WIDTH-1:0] t,
                                      output logic fire);
      fire = 1'b0;
      if (pend) begin
         if (t == '0) begin
            pend = 1'b0;
            fire = 1'b1;
         end else begin
            t = t - TIMER_WIDTH'(1);
            if (t == '0) begin
               pend = 1'b0;
               fire = 1'b1;
            end
         end
      end
   endfunction

   always_comb begin
      hjd_pkg::hjd_state_type s;
      logic [TIMER_WIDTH-1:0] det_t;
      logic [TIMER_WIDTH-1:0] set_t;
      logic [TIMER_WIDTH-1:0] pr_t;
      logic [TIMER_WIDTH-1:0] rl_t;
      logic fire;
      logic jack_ev;
      logic btn_ev;
      logic ignore;

      s = state_cur;
      det_t = detect_timer_cur;
      set_t = settle_timer_cur;
      pr_t = press_timer_cur;
      rl_t = release_timer_cur;
      fire = 1'b0;
      jack_ev = 1'b0;
      btn_ev = 1'b0;

      // Edges arm their timers unless that timer is already running; button edges only while armed.
      if (detect_level != s.last_detect && !s.pend_detect) begin
         s.pend_detect = 1'b1;
         det_t = clamp_delay(cfg.detect_debounce_ticks);
      end
      s.last_detect = detect_level;
      if (s.button_armed && button_level != s.last_button) begin
         if (button_level) begin
            if (!s.pend_press) begin
               s.pend_press = 1'b1;
               pr_t = clamp_delay(cfg.button_debounce_ticks);
            end
         end else if (!s.pend_release) begin
            s.pend_release = 1'b1;
            rl_t = clamp_delay(cfg.button_debounce_ticks);
         end
      end
      s.last_button = button_level;

      // While the pole pin settles, a detect expiry waits at zero.
      if (s.settling) begin
         if (s.pend_detect && det_t != '0) begin
            det_t = det_t - TIMER_WIDTH'(1);
         end
      end else begin
         tick_timer(s.pend_detect, det_t, fire);
         if (fire) begin
            if (detect_level) begin
               if (s.present_kind != hjd_pkg::JACK_NONE) begin
                  s.mic_drive = 1'b0;
                  s.present_kind = hjd_pkg::JACK_NONE;
                  s.button_armed = 1'b0;
                  if (s.held && !s.pend_release) begin
                     s.pend_release = 1'b1;
                     rl_t = clamp_delay(cfg.button_debounce_ticks);
                  end
                  jack_ev = 1'b1;
               end
            end else if (s.present_kind == hjd_pkg::JACK_NONE) begin
               s.mic_drive = 1'b1;
               s.settling = 1'b1;
               set_t = clamp_delay(cfg.pole_settle_ticks);
            end
         end
      end

      if (s.settling) begin
         if (set_t != '0) begin
            set_t = set_t - TIMER_WIDTH'(1);
         end
         if (set_t == '0) begin
            s.settling = 1'b0;
            if (pole_level) begin
               s.present_kind = hjd_pkg::JACK_THREE;
               s.mic_drive = 1'b0;
            end else begin
               s.present_kind = hjd_pkg::JACK_FOUR;
               s.button_armed = 1'b1;
            end
            jack_ev = 1'b1;
         end
      end

      // Button reports are dropped while a four-pole plug reads as removed.
      ignore = detect_level && (s.present_kind == hjd_pkg::JACK_FOUR);
      tick_timer(s.pend_press, pr_t, fire);
      if (fire && !ignore) begin
         s.held = 1'b1;
         btn_ev = 1'b1;
      end
      tick_timer(s.pend_release, rl_t, fire);
      if (fire && !ignore) begin
         s.held = 1'b0;
         btn_ev = 1'b1;
      end

      state_nxt = s;
      detect_timer_nxt = det_t;
      settle_timer_nxt = set_t;
      press_timer_nxt = pr_t;
      release_timer_nxt = rl_t;

      result.jack_state = s.present_kind;
      result.mic_enable = s.mic_drive;
      result.headphone_present = (s.present_kind != hjd_pkg::JACK_NONE);
      result.microphone_present = (s.present_kind == hjd_pkg::JACK_FOUR);
      result.button_down = s.held;
      result.jack_event = jack_ev;
      result.button_event = btn_ev;
   end

endmodule

// ===== hdl/headset_jack_detector_top.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tdata: detect, pole, button levels
// rsp_      out        rsp_tvalid/rsp_tready  tdata: jack state, presence, button
// csr_      in         APB write/read         three 16-bit timing registers
//
// One request is taken per cycle while no stalled response blocks it; its response appears in the next cycle.
// The response register is the only pipeline stage, and a request is taken
// whenever it is empty or is being drained in the same cycle.
// Synchronous active-high reset returns the detector state to its reset values and loads default timings.
// A stalled response holds its data and blocks further requests until taken.
module headset_jack_detector_top #(
   parameter int TIMER_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // bit 0 detect_level, bit 1 pole_level, bit 2 button_level, bits 7:3 zero
   input  logic [7:0]                          req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // bits 1:0 jack_state, 2 mic_enable, 3 headphone_present, 4 microphone_present,
   // 5 button_down, 6 jack_event, 7 button_event
   output logic [7:0]                          rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hjd_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [hjd_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [hjd_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);

   hjd_pkg::hjd_cfg_type   cfg_ff;
   hjd_pkg::hjd_state_type state_ff;
   hjd_pkg::hjd_state_type state_in;
   logic [TIMER_WIDTH-1:0] detect_timer_ff;
   logic [TIMER_WIDTH-1:0] detect_timer_in;
   logic [TIMER_WIDTH-1:0] settle_timer_ff;
   logic [TIMER_WIDTH-1:0] settle_timer_in;
   logic [TIMER_WIDTH-1:0] press_timer_ff;
   logic [TIMER_WIDTH-1:0] press_timer_in;
   logic [TIMER_WIDTH-1:0] release_timer_ff;
   logic [TIMER_WIDTH-1:0] release_timer_in;
   hjd_pkg::hjd_result_type result;
   logic                   rsp_tvalid_ff;
   logic [7:0]             rsp_tdata_ff;
   logic                   req_accept;
   logic                   csr_write;
   logic [1:0]             csr_index;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detect_debounce_ticks <= hjd_pkg::DETECT_DEBOUNCE_RESET;
         cfg_ff.pole_settle_ticks <= hjd_pkg::POLE_SETTLE_RESET;
         cfg_ff.button_debounce_ticks <= hjd_pkg::BUTTON_DEBOUNCE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            hjd_pkg::CSR_DETECT_DEBOUNCE: begin
               cfg_ff.detect_debounce_ticks <= csr_pwdata[hjd_pkg::CFG_WIDTH-1:0];
            end
            hjd_pkg::CSR_POLE_SETTLE: begin
               cfg_ff.pole_settle_ticks <= csr_pwdata[hjd_pkg::CFG_WIDTH-1:0];
            end
            hjd_pkg::CSR_BUTTON_DEBOUNCE: begin
               cfg_ff.button_debounce_ticks <= csr_pwdata[hjd_pkg::CFG_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         hjd_pkg::CSR_DETECT_DEBOUNCE: csr_prdata = 32'(cfg_ff.detect_debounce_ticks);
         hjd_pkg::CSR_POLE_SETTLE:     csr_prdata = 32'(cfg_ff.pole_settle_ticks);
         hjd_pkg::CSR_BUTTON_DEBOUNCE: csr_prdata = 32'(cfg_ff.button_debounce_ticks);
         default:                      csr_prdata = '0;
      endcase
   end

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   hjd_core #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_core (
      .cfg               (cfg_ff),
      .detect_level      (req_tdata[0]),
      .pole_level        (req_tdata[1]),
      .button_level      (req_tdata[2]),
      .state_cur         (state_ff),
      .detect_timer_cur  (detect_timer_ff),
      .settle_timer_cur  (settle_timer_ff),
      .press_timer_cur   (press_timer_ff),
      .release_timer_cur (release_timer_ff),
      .state_nxt         (state_in),
      .detect_timer_nxt  (detect_timer_in),
      .settle_timer_nxt  (settle_timer_in),
      .press_timer_nxt   (press_timer_in),
      .release_timer_nxt (release_timer_in),
      .result            (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hjd_pkg::STATE_RESET;
         detect_timer_ff <= '0;
         settle_timer_ff <= '0;
         press_timer_ff <= '0;
         release_timer_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
         detect_timer_ff <= detect_timer_in;
         settle_timer_ff <= settle_timer_in;
         press_timer_ff <= press_timer_in;
         release_timer_ff <= release_timer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_tdata_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;

`ifndef SYNTHESIS
   a_accept_gives_response: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no response");

   a_settle_keeps_mic: assert property (@(posedge clock) disable iff (reset)
      state_ff.settling |-> state_ff.mic_drive)
      else $error("mic drive dropped while the pole pin settles");

   a_armed_only_four_pole: assert property (@(posedge clock) disable iff (reset)
      state_ff.button_armed |-> state_ff.present_kind == hjd_pkg::JACK_FOUR)
      else $error("button armed without a four-pole headset");

   a_presence_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3] == (rsp_tdata[1:0] != 2'd0))
      else $error("headphone presence disagrees with jack state");
`endif

endmodule

// ===== test/headset_jack_detector_top_tb.sv =====
`timescale 1ns / 1ps

module headset_jack_detector_top_tb;

   localparam int unsigned RANDOM_TICKS    = 1250;
   localparam int unsigned HOLD_OFF_CYCLES = 60;
   localparam logic [hjd_pkg::CSR_ADDR_WIDTH-1:0] CSR_ADDR_SPARE = 4'hC;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [7:0]                         req_tdata = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [7:0]                         rsp_tdata;
   logic                               csr_psel = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite = 1'b0;
   logic [hjd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [hjd_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [hjd_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                               csr_pready;

   // Test control shared by the stimulus, the response sink and the hold-off process.
   logic        idle_mode = 1'b1;
   logic        sink_hold = 1'b0;
   event        hold_off_kick;
   int unsigned ticks_sent = 0;
   int unsigned status_checked = 0;
   int unsigned error_count = 0;
   int unsigned config_phases = 0;
   int unsigned sessions_run = 0;

   hjd_pkg::hjd_result_type predicted_status[$];

   // Shadow of the timing registers, used by the predictor.
   logic [15:0] cfg_detect = hjd_pkg::DETECT_DEBOUNCE_RESET;
   logic [15:0] cfg_settle = hjd_pkg::POLE_SETTLE_RESET;
   logic [15:0] cfg_button = hjd_pkg::BUTTON_DEBOUNCE_RESET;

   // Predictor state of the detector.
   logic                   seen_detect = 1'b1;
   logic                   seen_button = 1'b0;
   hjd_pkg::jack_kind_type plug_kind = hjd_pkg::JACK_NONE;
   logic                   pole_wait = 1'b0;
   logic                   detect_pend = 1'b0;
   logic                   press_pend = 1'b0;
   logic                   release_pend = 1'b0;
   logic                   button_live = 1'b0;
   logic                   button_held = 1'b0;
   logic                   mic_on = 1'b0;
   int unsigned            detect_count = 0;
   int unsigned            pole_count = 0;
   int unsigned            press_count = 0;
   int unsigned            release_count = 0;

   headset_jack_detector_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endfunction

   // A pending timer is never restarted by a further edge.
   function automatic void arm_timer(inout logic pending, inout int unsigned count,
                                     input int unsigned delay);
      if (!pending) begin
         pending = 1'b1;
         count   = delay;
      end
   endfunction

   function automatic bit timer_expires(inout logic pending, inout int unsigned count);
      if (!pending) begin
         return 1'b0;
      end
      if (count != 0) begin
         count--;
      end
      if (count == 0) begin
         pending = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic hjd_pkg::hjd_result_type jack_tick_predict(input logic det,
                                                                 input logic pole,
                                                                 input logic btn);
      hjd_pkg::hjd_result_type status;
      logic                    jack_pulse;
      logic                    button_pulse;
      jack_pulse   = 1'b0;
      button_pulse = 1'b0;

      if (det != seen_detect) begin
         arm_timer(detect_pend, detect_count, 32'(cfg_detect));
      end
      seen_detect = det;
      if (button_live && btn != seen_button) begin
         if (btn) begin
            arm_timer(press_pend, press_count, 32'(cfg_button));
         end else begin
            arm_timer(release_pend, release_count, 32'(cfg_button));
         end
      end
      seen_button = btn;

      // While the pole pin settles, a detect expiry is parked at zero.
      if (pole_wait) begin
         if (detect_pend && detect_count != 0) begin
            detect_count--;
         end
      end else if (timer_expires(detect_pend, detect_count)) begin
         if (det) begin
            if (plug_kind != hjd_pkg::JACK_NONE) begin
               mic_on      = 1'b0;
               plug_kind   = hjd_pkg::JACK_NONE;
               button_live = 1'b0;
               if (button_held) begin
                  arm_timer(release_pend, release_count, 32'(cfg_button));
               end
               jack_pulse = 1'b1;
            end
         end else if (plug_kind == hjd_pkg::JACK_NONE) begin
            mic_on     = 1'b1;
            pole_wait  = 1'b1;
            pole_count = 32'(cfg_settle);
         end
      end

      if (pole_wait) begin
         if (pole_count != 0) begin
            pole_count--;
         end
         if (pole_count == 0) begin
            pole_wait = 1'b0;
            if (pole) begin
               plug_kind = hjd_pkg::JACK_THREE;
               mic_on    = 1'b0;
            end else begin
               plug_kind   = hjd_pkg::JACK_FOUR;
               button_live = 1'b1;
            end
            jack_pulse = 1'b1;
         end
      end

      // A button report is dropped while the jack reads removed on a four-pole plug.
      if (timer_expires(press_pend, press_count) &&
          !(det && plug_kind == hjd_pkg::JACK_FOUR)) begin
         button_held  = 1'b1;
         button_pulse = 1'b1;
      end
      if (timer_expires(release_pend, release_count) &&
          !(det && plug_kind == hjd_pkg::JACK_FOUR)) begin
         button_held  = 1'b0;
         button_pulse = 1'b1;
      end

      status.jack_state         = plug_kind;
      status.mic_enable         = mic_on;
      status.headphone_present  = (plug_kind != hjd_pkg::JACK_NONE);
      status.microphone_present = (plug_kind == hjd_pkg::JACK_FOUR);
      status.button_down        = button_held;
      status.jack_event         = jack_pulse;
      status.button_event       = button_pulse;
      return status;
   endfunction

   // Response sink with random back-pressure in idle mode, always ready otherwise; the hold-off process overrides it.
   always @(posedge clock) begin
      if (sink_hold) begin
         rsp_tready <= 1'b0;
      end else if (idle_mode) begin
         rsp_tready <= ($urandom_range(99, 0) >= 29);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      forever begin
         @(hold_off_kick);
         sink_hold <= 1'b1;
         repeat (HOLD_OFF_CYCLES) @(posedge clock);
         sink_hold <= 1'b0;
      end
   end

   always @(posedge clock) begin : status_check
      hjd_pkg::hjd_result_type got;
      hjd_pkg::hjd_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = hjd_pkg::hjd_result_type'(rsp_tdata);
         if (predicted_status.size() == 0) begin
            flag_error($sformatf("status 0x%02h with no request outstanding", rsp_tdata));
         end else begin
            want = predicted_status.pop_front();
            if (got.jack_state !== want.jack_state)
               flag_error($sformatf("jack_state expected %0d, got %0d",
                                    want.jack_state, got.jack_state));
            if (got.mic_enable !== want.mic_enable)
               flag_error($sformatf("mic_enable expected %b, got %b",
                                    want.mic_enable, got.mic_enable));
            if (got.headphone_present !== want.headphone_present)
               flag_error($sformatf("headphone_present expected %b, got %b",
                                    want.headphone_present, got.headphone_present));
            if (got.microphone_present !== want.microphone_present)
               flag_error($sformatf("microphone_present expected %b, got %b",
                                    want.microphone_present, got.microphone_present));
            if (got.button_down !== want.button_down)
               flag_error($sformatf("button_down expected %b, got %b",
                                    want.button_down, got.button_down));
            if (got.jack_event !== want.jack_event)
               flag_error($sformatf("jack_event expected %b, got %b",
                                    want.jack_event, got.jack_event));
            if (got.button_event !== want.button_event)
               flag_error($sformatf("button_event expected %b, got %b",
                                    want.button_event, got.button_event));
         end
         status_checked++;
      end
   end

   task automatic send_tick(input logic det, input logic pole, input logic btn);
      while (idle_mode && $urandom_range(99, 0) < 29) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, btn, pole, det};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted_status.push_back(jack_tick_predict(det, pole, btn));
      ticks_sent++;
   endtask

   task automatic hold_pins(input logic det, input logic pole, input logic btn,
                            input int unsigned ticks);
      repeat (ticks) send_tick(det, pole, btn);
   endtask

   task automatic wait_status_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (status_checked != ticks_sent) @(posedge clock);
   endtask

   function automatic logic [hjd_pkg::CSR_ADDR_WIDTH-1:0] reg_addr(
      input hjd_pkg::csr_index_type idx);
      return {idx, 2'b00};
   endfunction

   task automatic csr_read_check(input logic [hjd_pkg::CSR_ADDR_WIDTH-1:0] addr,
                                 input logic [15:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_pready !== 1'b1) begin
         flag_error("register port not ready during an access cycle");
      end
      if (csr_prdata[15:0] !== want) begin
         flag_error($sformatf("register at 0x%0h reads %0d, expected %0d",
                              addr, csr_prdata[15:0], want));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Writes carry random upper data bits; only the low 16 bits are kept.
   task automatic csr_write(input logic [hjd_pkg::CSR_ADDR_WIDTH-1:0] addr,
                            input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      if (addr == reg_addr(hjd_pkg::CSR_DETECT_DEBOUNCE)) begin
         cfg_detect = value;
         csr_read_check(addr, value);
      end else if (addr == reg_addr(hjd_pkg::CSR_POLE_SETTLE)) begin
         cfg_settle = value;
         csr_read_check(addr, value);
      end else if (addr == reg_addr(hjd_pkg::CSR_BUTTON_DEBOUNCE)) begin
         cfg_button = value;
         csr_read_check(addr, value);
      end
   endtask

   task automatic check_all_csrs();
      csr_read_check(reg_addr(hjd_pkg::CSR_DETECT_DEBOUNCE), cfg_detect);
      csr_read_check(reg_addr(hjd_pkg::CSR_POLE_SETTLE), cfg_settle);
      csr_read_check(reg_addr(hjd_pkg::CSR_BUTTON_DEBOUNCE), cfg_button);
   endtask

   task automatic write_timings(input logic [15:0] det_ticks, input logic [15:0] settle_ticks,
                                input logic [15:0] button_ticks);
      wait_status_drained();
      csr_write(reg_addr(hjd_pkg::CSR_DETECT_DEBOUNCE), det_ticks);
      csr_write(reg_addr(hjd_pkg::CSR_POLE_SETTLE), settle_ticks);
      csr_write(reg_addr(hjd_pkg::CSR_BUTTON_DEBOUNCE), button_ticks);
      config_phases++;
   endtask

   function automatic logic [15:0] pick_delay();
      case ($urandom_range(9, 0))
         0: return 16'd0;
         1: return 16'd1;
         default: return 16'($urandom_range(20, 2));
      endcase
   endfunction

   // Mostly full hold times, sometimes a short bounce.
   function automatic int unsigned hold_span(input int unsigned base);
      if ($urandom_range(3, 0) == 0) begin
         return $urandom_range(base + 1, 1);
      end
      return base + $urandom_range(3, 0);
   endfunction

   task automatic plug_session();
      logic        three;
      logic        btn_at_removal;
      int unsigned presses;
      three          = 1'($urandom_range(1, 0));
      presses        = $urandom_range(4, 0);
      btn_at_removal = 1'b0;
      repeat ($urandom_range(2, 0)) begin
         hold_pins(1'b0, three, 1'b0, $urandom_range(3, 1));
         hold_pins(1'b1, three, 1'b0, $urandom_range(3, 1));
      end
      hold_pins(1'b0, three, 1'b0, int'(cfg_detect) + int'(cfg_settle) + $urandom_range(3, 1));
      repeat (presses) begin
         hold_pins(1'b0, three, 1'b1, hold_span(32'(cfg_button)));
         hold_pins(1'b0, three, 1'b0, hold_span(32'(cfg_button)));
      end
      if ($urandom_range(2, 0) == 0) begin
         btn_at_removal = 1'b1;
         hold_pins(1'b0, three, 1'b1, int'(cfg_button) + 2);
      end
      hold_pins(1'b1, three, btn_at_removal, hold_span(32'(cfg_detect)));
      hold_pins(1'b1, three, 1'b0, int'(cfg_detect) + int'(cfg_button) + 2);
      sessions_run++;
   endtask

   task automatic noise_burst(input int unsigned ticks);
      logic [2:0] pins;
      repeat (ticks) begin
         pins = 3'($urandom);
         hold_pins(pins[0], pins[1], pins[2], $urandom_range(3, 1));
      end
   endtask

   task automatic test_reset_values();
      check_all_csrs();
   endtask

   task automatic test_spare_address();
      wait_status_drained();
      csr_write(CSR_ADDR_SPARE, 16'($urandom));
      check_all_csrs();
   endtask

   // All timers at zero: every edge that is acted on takes effect in the tick that sees it.
   task automatic test_zero_delays();
      write_timings(16'd0, 16'd0, 16'd0);
      hold_pins(1'b1, 1'b0, 1'b0, 1);
      hold_pins(1'b0, 1'b0, 1'b0, 1);
      hold_pins(1'b0, 1'b0, 1'b1, 1);
      hold_pins(1'b0, 1'b0, 1'b0, 1);
      hold_pins(1'b0, 1'b0, 1'b1, 1);
      // Removal with the button held releases it on the same tick.
      hold_pins(1'b1, 1'b1, 1'b1, 1);
      hold_pins(1'b0, 1'b1, 1'b0, 1);
      // Three-pole plug: the button is not armed.
      hold_pins(1'b0, 1'b1, 1'b1, 1);
      hold_pins(1'b1, 1'b0, 1'b0, 1);
   endtask

   task automatic test_timer_corners();
      write_timings(16'd2, 16'd5, 16'd1);
      // A detect bounce during the pole settle expires late and changes nothing.
      hold_pins(1'b0, 1'b0, 1'b0, 2);
      hold_pins(1'b1, 1'b0, 1'b0, 1);
      hold_pins(1'b0, 1'b0, 1'b0, 6);
      hold_pins(1'b0, 1'b0, 1'b1, 1);
      // Release seen while the jack reads removed is dropped, then press and
      // release land in the removal tick.
      hold_pins(1'b1, 1'b0, 1'b0, 1);
      hold_pins(1'b1, 1'b0, 1'b1, 1);
      // Removal evaluated with nothing plugged in.
      hold_pins(1'b0, 1'b1, 1'b0, 1);
      hold_pins(1'b1, 1'b1, 1'b0, 1);
   endtask

   task automatic test_long_timers();
      write_timings(16'd150, 16'd60, 16'd90);
      idle_mode <= 1'b0;
      hold_pins(1'b1, 1'b1, 1'b0, 4);
      hold_pins(1'b0, 1'b0, 1'b0, 32'(cfg_detect) + 32'(cfg_settle) + 4);
      hold_pins(1'b0, 1'b0, 1'b1, 32'(cfg_button) + 4);
      wait_status_drained();
      idle_mode <= 1'b1;
   endtask

   task automatic test_back_pressure();
      write_timings(16'd3, 16'd2, 16'd2);
      -> hold_off_kick;
      noise_burst(25);
      plug_session();
   endtask

   task automatic test_random_sessions();
      int unsigned first_tick;
      first_tick = ticks_sent;
      while (ticks_sent - first_tick < RANDOM_TICKS) begin
         write_timings(pick_delay(), pick_delay(), pick_delay());
         repeat (3) plug_session();
         noise_burst($urandom_range(30, 10));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_zero_delays();
      test_timer_corners();
      test_spare_address();
      test_long_timers();
      test_back_pressure();
      test_random_sessions();
      wait_status_drained();
      repeat (10) @(posedge clock);
      if (predicted_status.size() != 0) begin
         flag_error($sformatf("%0d statuses never arrived", predicted_status.size()));
      end
      $display("Run covered %0d ticks and %0d statuses over %0d timing setups, %0d plug sessions.",
               ticks_sent, status_checked, config_phases, sessions_run);
      $display("Timings ranged from zero to a few hundred ticks; %0d errors found.",
               error_count);
      if (error_count == 0) begin
         $display("PASS headset_jack_detector_top");
      end else begin
         $display("FAIL headset_jack_detector_top");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("FAIL headset_jack_detector_top");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/hjd_pkg.sv
hdl/hjd_core.sv
hdl/headset_jack_detector_top.sv
test/headset_jack_detector_top_tb.sv
